FILE: design/ftar_pkg.sv
// Shared types and constants of the fat tree aggregate router.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package ftar_pkg;

  localparam int DOWN_PORTS = 4;
  localparam int FILL_BITS  = 8;
  localparam int NODE_BITS  = 16;

  // Port mask before it is cut to the 8-bit output field.
  localparam int MASK_W  = 2 * DOWN_PORTS;
  localparam int SHAMT_W = $clog2(MASK_W);
  localparam int SPAN    = DOWN_PORTS * DOWN_PORTS;
  localparam int DEST_W  = (NODE_BITS < 16) ? NODE_BITS : 16;
  localparam int FIRST_W = $clog2(256 * DOWN_PORTS);
  localparam int CMP_W   = ((DEST_W > FIRST_W) ? DEST_W : FIRST_W) + 1;
  localparam int IDX_W   = (DOWN_PORTS > 1) ? $clog2(DOWN_PORTS) : 1;
  localparam int FILL_PAD_W = (DOWN_PORTS * FILL_BITS > 32) ? DOWN_PORTS * FILL_BITS : 32;

  // Reciprocal for switch_id / DOWN_PORTS; exact for every 8-bit id.
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((1 << RECIP_SH) + DOWN_PORTS - 1) / DOWN_PORTS;
  localparam int RECIP_W  = RECIP_SH + 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MK_UNICAST = 3'd0,
    MK_BCAST   = 3'd1,
    MK_BAR_REQ = 3'd2,
    MK_BAR_REL = 3'd3,
    MK_OTHER   = 3'd4
  } msg_kind_t;

  typedef enum logic [1:0] {
    FK_UNICAST = 2'd0,
    FK_BCAST   = 2'd1,
    FK_BAR_REQ = 2'd2,
    FK_BAR_REL = 2'd3
  } fwd_kind_t;

  typedef enum logic [1:0] {
    ST_OK            = 2'd0,
    ST_REQ_FROM_UP   = 2'd1,
    ST_REL_FROM_DOWN = 2'd2,
    ST_UNKNOWN       = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]            mask;
    fwd_kind_t             kind;
    logic [15:0]           dest;
    logic [31:0]           payload;
    status_t               status;
    logic                  is_rel;
    logic [DOWN_PORTS-1:0] rel_bit;
  } qent_t;

  localparam logic [MASK_W-1:0] ALL_UP_MASK   = MASK_W'((1 << DOWN_PORTS) - 1);
  localparam logic [MASK_W-1:0] ALL_DOWN_MASK = ~ALL_UP_MASK;

endpackage

`default_nettype wire

FILE: design/fat_tree_aggregate_router_unit.sv
// Top level of the fat tree aggregate router: front end, entry queue, back end.
// Depends on ftar_pkg, ftar_front, ftar_queue and ftar_back.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    msg_kind, source_port, dest_node, payload, fill
//   out      out_valid / out_stall  port_mask, kind, dest, payload, status
//   cfg      cfg_valid / cfg_ready  cfg_data (switch id)
//
// One message per cycle sustained while out_stall is low. A message is classified
// and written into the queue when it is taken, and from the queue head it loads
// the back end output register once that register is empty or being read.
// The two-entry queue lets the input keep moving while an output is stalled;
// in_stall rises only when the queue is full. Synchronous active-low reset
// clears the queue, the output valid, the group base and the release flags.
`default_nettype none

module fat_tree_aggregate_router_unit
  import ftar_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_msg_kind,
  input  wire logic [2:0]  in_source_port,
  input  wire logic [15:0] in_dest_node,
  input  wire logic [31:0] in_payload,
  input  wire logic [31:0] in_up_fill_levels,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_port_mask,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_dest,
  output logic [31:0]      out_payload,
  output logic [1:0]       out_status
);

  qent_t front_ent;
  qent_t q_head;
  logic  q_full, q_valid, q_pop, push;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  ftar_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_valid),
    .cfg_data       (cfg_data),
    .msg_kind       (in_msg_kind),
    .source_port    (in_source_port),
    .dest_node      (in_dest_node),
    .payload        (in_payload),
    .up_fill_levels (in_up_fill_levels),
    .ent            (front_ent)
  );

  ftar_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_ent  (front_ent),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head      (q_head)
  );

  ftar_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .port_mask   (out_port_mask),
    .out_kind    (out_kind),
    .out_dest    (out_dest),
    .out_payload (out_payload),
    .status      (out_status)
  );

endmodule

`default_nettype wire

FILE: design/ftar_front.sv
// Front end: holds the switch group base and classifies each arriving message
// into a queue entry (mask, forwarded fields, status). Depends on ftar_pkg.
`default_nettype none

module ftar_front
  import ftar_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic [2:0]  msg_kind,
  input  wire logic [2:0]  source_port,
  input  wire logic [15:0] dest_node,
  input  wire logic [31:0] payload,
  input  wire logic [31:0] up_fill_levels,
  output qent_t            ent
);

  logic [FIRST_W-1:0] first_r;
  logic [FIRST_W-1:0] first_nxt;
  logic [8+RECIP_W-1:0] prod;
  logic [7:0]           grp;

  // Group base is registered whenever the id is written.
  always_comb begin
    prod      = {{RECIP_W{1'b0}}, cfg_data} * (8 + RECIP_W)'(RECIP);
    grp       = 8'(prod >> RECIP_SH);
    first_nxt = FIRST_W'(grp * FIRST_W'(SPAN));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
    end else if (cfg_we) begin
      first_r <= first_nxt;
    end
  end

  logic [DEST_W-1:0]     dest_m;
  logic [CMP_W-1:0]      d_ext, f_ext, diff;
  logic                  in_grp;
  logic [SHAMT_W-1:0]    down_k;
  logic [FILL_PAD_W-1:0] fills;
  logic [FILL_BITS-1:0]  best_fill, cur_fill;
  logic [IDX_W-1:0]      best;
  logic                  from_up;
  logic [MASK_W-1:0]     m;

  always_comb begin
    dest_m = dest_node[DEST_W-1:0];
    d_ext  = CMP_W'(dest_m);
    f_ext  = CMP_W'(first_r);
    diff   = d_ext - f_ext;
    in_grp = (d_ext >= f_ext) && (diff < CMP_W'(SPAN));
    down_k = '0;
    for (int j = 1; j < DOWN_PORTS; j++) begin
      down_k = down_k + SHAMT_W'(diff >= CMP_W'(j * DOWN_PORTS));
    end
  end

  // Least-filled up port; a strict compare keeps the lowest index on ties.
  always_comb begin
    fills     = FILL_PAD_W'(up_fill_levels);
    best      = '0;
    best_fill = fills[FILL_BITS-1:0];
    for (int i = 1; i < DOWN_PORTS; i++) begin
      cur_fill = fills[i*FILL_BITS +: FILL_BITS];
      if (cur_fill < best_fill) begin
        best      = IDX_W'(i);
        best_fill = cur_fill;
      end
    end
  end

  always_comb begin
    from_up     = (4'(source_port) < 4'(DOWN_PORTS));
    m           = '0;
    ent.mask    = '0;
    ent.kind    = FK_UNICAST;
    ent.dest    = '0;
    ent.payload = '0;
    ent.status  = ST_OK;
    ent.is_rel  = 1'b0;
    ent.rel_bit = '0;
    unique case (msg_kind_t'(msg_kind))
      MK_UNICAST: begin
        if (in_grp) begin
          m = MASK_W'(1) << (SHAMT_W'(DOWN_PORTS) + down_k);
        end else begin
          m = MASK_W'(1) << best;
        end
        ent.kind    = FK_UNICAST;
        ent.dest    = 16'(dest_m);
        ent.payload = payload;
      end
      MK_BCAST: begin
        m = ALL_DOWN_MASK;
        if (!from_up) begin
          if (5'(source_port) < 5'(MASK_W)) begin
            m[SHAMT_W'(source_port)] = 1'b0;
          end
          m = m | (MASK_W'(1) << best);
        end
        ent.kind    = FK_BCAST;
        ent.dest    = 16'(dest_m);
        ent.payload = payload;
      end
      MK_BAR_REQ: begin
        if (from_up) begin
          ent.status = ST_REQ_FROM_UP;
        end else begin
          m           = ALL_UP_MASK;
          ent.kind    = FK_BAR_REQ;
          ent.dest    = 16'(dest_m);
          ent.payload = payload;
        end
      end
      MK_BAR_REL: begin
        if (!from_up) begin
          ent.status = ST_REL_FROM_DOWN;
        end else begin
          ent.kind    = FK_BAR_REL;
          ent.is_rel  = 1'b1;
          ent.rel_bit = DOWN_PORTS'(1) << source_port;
        end
      end
      default: begin
        ent.status = ST_UNKNOWN;
      end
    endcase
    ent.mask = 8'(m);
  end

endmodule

`default_nettype wire

FILE: design/ftar_queue.sv
// Short queue of classified entries between the front and the back end.
// Depends on ftar_pkg for the entry type and depth.
`default_nettype none

module ftar_queue
  import ftar_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire qent_t push_ent,
  input  wire logic  pop,
  output logic       full,
  output logic       not_empty,
  output qent_t      head
);

  qent_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_ent;
    end
  end

endmodule

`default_nettype wire

FILE: design/ftar_back.sv
// Back end: applies barrier release collection and drives the output register.
// Depends on ftar_pkg for the entry type and port masks.
`default_nettype none

module ftar_back
  import ftar_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         q_valid,
  input  wire qent_t        q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [7:0]        port_mask,
  output logic [1:0]        out_kind,
  output logic [15:0]       out_dest,
  output logic [31:0]       out_payload,
  output logic [1:0]        status
);

  logic [DOWN_PORTS-1:0] seen_r, seen_nxt, seen_or;
  logic                  valid_r, valid_nxt;
  logic [7:0]            mask_r, mask_nxt;
  fwd_kind_t             kind_r;
  logic [15:0]           dest_r;
  logic [31:0]           pay_r;
  status_t               status_r;

  assign q_pop = q_valid && (!valid_r || !out_stall);

  always_comb begin
    seen_or   = seen_r | q_head.rel_bit;
    seen_nxt  = seen_r;
    mask_nxt  = q_head.mask;
    valid_nxt = valid_r && out_stall;
    if (q_pop) begin
      valid_nxt = 1'b1;
      if (q_head.is_rel) begin
        // The last missing release fans out to every down port.
        if (&seen_or) begin
          mask_nxt = 8'(ALL_DOWN_MASK);
          seen_nxt = '0;
        end else begin
          seen_nxt = seen_or;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mask_r   <= mask_nxt;
      kind_r   <= q_head.kind;
      dest_r   <= q_head.dest;
      pay_r    <= q_head.payload;
      status_r <= q_head.status;
    end
  end

  assign out_valid   = valid_r;
  assign port_mask   = mask_r;
  assign out_kind    = kind_r;
  assign out_dest    = dest_r;
  assign out_payload = pay_r;
  assign status      = status_r;

endmodule

`default_nettype wire
